FILE: design/utf32_to_utf8_string_encoder_core_assert.svh
// ----------------------------------------------------------------------------
// utf32 to utf8 encoder assertion macros
// implication checks on the core clock, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef UTF32_TO_UTF8_STRING_ENCODER_CORE_ASSERT_SVH
`define UTF32_TO_UTF8_STRING_ENCODER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define U8E_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8enc assertion failed");
// next-cycle implication
`define U8E_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8enc assertion failed");
`else
`define U8E_ASSERT_IMPL(label, ante, cons)
`define U8E_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: design/u8enc_pkg.sv
// ----------------------------------------------------------------------------
// u8enc package
// shared types and constants of the utf32 to utf8 encoder
// ----------------------------------------------------------------------------
package u8enc_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LITTLE_ENDIAN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CAPACITY  = 1'b1;

  localparam logic [15:0] CAP_RESET = 16'hFFFF;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;

  // shift amounts of the continuation groups
  localparam int unsigned SH_1 = 6;
  localparam int unsigned SH_2 = 12;
  localparam int unsigned SH_3 = 18;

  // queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  typedef struct packed {
    logic        little_endian;
    logic [15:0] capacity;
  } cfg_t;

  // one classified item: up to four bytes, first byte in lane 0
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last;
    logic            term;
    logic [1:0]      status;
    logic [15:0]     len;
  } entry_t;

endpackage

FILE: design/u8enc_front.sv
// ----------------------------------------------------------------------------
// u8enc front end
// byte swap, validity and room checks, string state, entry build
// ----------------------------------------------------------------------------
module u8enc_front #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_code_word,
  input  u8enc_pkg::cfg_t   cfg,
  input  logic              q_full,
  output logic              push,
  output u8enc_pkg::entry_t entry
);

  localparam int unsigned CW   = COUNT_WIDTH;
  localparam int unsigned CAPW = (CW > 16) ? CW : 16;
  localparam int unsigned LW   = (CW + 1 > 16) ? CW + 1 : 16;
  localparam logic [63:0] LIM64 = (64'd1 << CW) - 64'd1;
  localparam logic [CAPW-1:0] LIM = LIM64[CAPW-1:0];

  logic          error_seen_r, error_seen_nxt;
  logic [CW-1:0] bytes_used_r, bytes_used_nxt;
  logic          closed_r, closed_nxt;

  logic [31:0]   w, w6, w12, w18;
  logic          is_zero, invalid, drop, accept;
  logic [2:0]    n;
  logic [CAPW-1:0] cap_ext, cap_clip;
  logic [CW-1:0] cap_use;
  logic [CW:0]   sum, lenw;
  logic [LW-1:0] len_ext;
  logic [3:0][7:0] data_bytes;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    w = cfg.little_endian ?
        {in_code_word[7:0], in_code_word[15:8], in_code_word[23:16], in_code_word[31:24]} :
        in_code_word;
    w6  = w >> u8enc_pkg::SH_1;
    w12 = w >> u8enc_pkg::SH_2;
    w18 = w >> u8enc_pkg::SH_3;
    is_zero = (w == 32'd0);
    invalid = (w > 32'h0010_FFFF) || ((w >= 32'h0000_D800) && (w <= 32'h0000_DFFF));
    if (w < 32'h80) begin
      n = 3'd1;
    end else if (w < 32'h800) begin
      n = 3'd2;
    end else if (w < 32'h1_0000) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
  end

  // capacity in use: zero reads as one, clipped to what the count can hold
  always_comb begin
    cap_ext  = CAPW'(cfg.capacity);
    cap_clip = (cap_ext > LIM) ? LIM : cap_ext;
    cap_use  = (cap_clip == '0) ? CW'(1) : cap_clip[CW-1:0];
    sum      = {1'b0, bytes_used_r} + (CW + 1)'(n);
    lenw     = {1'b0, bytes_used_r} + (CW + 1)'(1);
    len_ext  = LW'(lenw);
  end

  always_comb begin
    data_bytes = '0;
    case (n)
      3'd1: data_bytes[0] = w[7:0];
      3'd2: begin
        data_bytes[0] = {3'b110, w6[4:0]};
        data_bytes[1] = {2'b10, w[5:0]};
      end
      3'd3: begin
        data_bytes[0] = {4'b1110, w12[3:0]};
        data_bytes[1] = {2'b10, w6[5:0]};
        data_bytes[2] = {2'b10, w[5:0]};
      end
      3'd4: begin
        data_bytes[0] = {5'b11110, w18[2:0]};
        data_bytes[1] = {2'b10, w12[5:0]};
        data_bytes[2] = {2'b10, w6[5:0]};
        data_bytes[3] = {2'b10, w[5:0]};
      end
      default: data_bytes = '0;
    endcase
  end

  // classification and next string state
  always_comb begin
    error_seen_nxt = error_seen_r;
    bytes_used_nxt = bytes_used_r;
    closed_nxt     = closed_r;
    drop           = 1'b0;
    entry          = '0;
    entry.term     = 1'b1;
    entry.len      = len_ext[15:0];
    if (is_zero) begin
      bytes_used_nxt = '0;
      closed_nxt     = 1'b0;
      drop           = closed_r;
      entry.status   = error_seen_r ? u8enc_pkg::ST_INVALID : u8enc_pkg::ST_OK;
    end else if (closed_r) begin
      drop = 1'b1;
    end else if (error_seen_r || invalid) begin
      error_seen_nxt = 1'b1;
      bytes_used_nxt = '0;
      closed_nxt     = 1'b1;
      entry.status   = u8enc_pkg::ST_INVALID;
    end else if (sum >= {1'b0, cap_use}) begin
      bytes_used_nxt = '0;
      closed_nxt     = 1'b1;
      entry.status   = u8enc_pkg::ST_TRUNC;
    end else begin
      bytes_used_nxt = sum[CW-1:0];
      entry.term     = 1'b0;
      entry.len      = '0;
      entry.bytes    = data_bytes;
      entry.last     = 2'(n - 3'd1);
    end
  end

  assign push = accept && !drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_seen_r <= 1'b0;
      bytes_used_r <= '0;
      closed_r     <= 1'b0;
    end else if (accept) begin
      error_seen_r <= error_seen_nxt;
      bytes_used_r <= bytes_used_nxt;
      closed_r     <= closed_nxt;
    end
  end

endmodule

FILE: design/u8enc_queue.sv
// ----------------------------------------------------------------------------
// u8enc queue
// two-entry fifo of classified items between front and back
// ----------------------------------------------------------------------------
module u8enc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  u8enc_pkg::entry_t push_entry,
  input  logic              pop,
  output u8enc_pkg::entry_t head,
  output logic              full,
  output logic              empty
);

  localparam logic [u8enc_pkg::Q_PTR_W-1:0] PTR_LAST =
    u8enc_pkg::Q_PTR_W'(u8enc_pkg::Q_DEPTH - 1);
  localparam logic [u8enc_pkg::Q_CNT_W-1:0] CNT_FULL =
    u8enc_pkg::Q_CNT_W'(u8enc_pkg::Q_DEPTH);

  u8enc_pkg::entry_t                  mem_r [u8enc_pkg::Q_DEPTH];
  logic [u8enc_pkg::Q_PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [u8enc_pkg::Q_CNT_W-1:0]      cnt_r;
  logic                               do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: design/u8enc_back.sv
// ----------------------------------------------------------------------------
// u8enc back end
// byte serialiser: shifts one queued item out a byte per handshake
// ----------------------------------------------------------------------------
module u8enc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  u8enc_pkg::entry_t head,
  input  logic              q_empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_end_of_item,
  output logic              out_is_terminator,
  output logic [1:0]        out_status,
  output logic [15:0]       out_string_length
);

  logic            valid_r;
  logic [3:0][7:0] bytes_r;
  logic [1:0]      rem_r;
  logic            term_r;
  logic [1:0]      status_r;
  logic [15:0]     len_r;
  logic            last_sent, load;

  assign out_valid         = valid_r;
  assign out_byte          = bytes_r[0];
  assign out_end_of_item   = (rem_r == 2'd0);
  assign out_is_terminator = term_r;
  assign out_status        = status_r;
  assign out_string_length = len_r;

  assign last_sent = valid_r && out_ready && (rem_r == 2'd0);
  assign load      = !valid_r || last_sent;
  assign pop       = load && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bytes_r  <= head.bytes;
      rem_r    <= head.last;
      term_r   <= head.term;
      status_r <= head.status;
      len_r    <= head.len;
    end else if (valid_r && out_ready && (rem_r != 2'd0)) begin
      bytes_r <= {8'h00, bytes_r[3:1]};
      rem_r   <= rem_r - 2'd1;
    end
  end

endmodule

FILE: design/utf32_to_utf8_string_encoder_core.sv
// ----------------------------------------------------------------------------
// utf32 to utf8 string encoder core
// encodes utf32 code words into utf8 bytes with string terminators
// ----------------------------------------------------------------------------
//
//  channel  handshake             payload
//  -------  --------------------  ------------------------------------------
//  in       in_valid / in_ready   in_code_word
//  out      out_valid / out_ready out_byte, out_end_of_item,
//                                 out_is_terminator, out_status,
//                                 out_string_length
//  cfg      cfg_we                cfg_index, cfg_wdata
//
//  the front is combinational and pushes an item in the cycle it accepts
//  the word; the serialiser in the back sends one byte per cycle while
//  out_ready is high, an item being 1 to 4 bytes; a dropped word sends nothing
//  in_ready only depends on room in the two-entry queue, not on out_ready
//  synchronous active-low reset clears string state, queue and output valid;
//  configuration resets to big-endian input and full capacity
//
module utf32_to_utf8_string_encoder_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [31:0]                         in_code_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_byte,
  output logic                                out_end_of_item,
  output logic                                out_is_terminator,
  output logic [1:0]                          out_status,
  output logic [15:0]                         out_string_length,
  input  logic                                cfg_we,
  input  logic [u8enc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [u8enc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

`include "utf32_to_utf8_string_encoder_core_assert.svh"

  // configuration registers
  u8enc_pkg::cfg_t   cfg_r;

  // front to queue, queue to back
  logic              push, pop, q_full, q_empty;
  u8enc_pkg::entry_t push_entry, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.little_endian <= 1'b0;
      cfg_r.capacity      <= u8enc_pkg::CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        u8enc_pkg::REG_LITTLE_ENDIAN: cfg_r.little_endian <= cfg_wdata[0];
        u8enc_pkg::REG_OUT_CAPACITY:  cfg_r.capacity      <= cfg_wdata;
        default:                      cfg_r               <= cfg_r;
      endcase
    end
  end

  // classify each word and keep the per-string state
  u8enc_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_code_word (in_code_word),
    .cfg          (cfg_r),
    .q_full       (q_full),
    .push         (push),
    .entry        (push_entry)
  );

  // decouples input acceptance from output stalls
  u8enc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // byte serialiser and output register
  u8enc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .q_empty           (q_empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_end_of_item   (out_end_of_item),
    .out_is_terminator (out_is_terminator),
    .out_status        (out_status),
    .out_string_length (out_string_length)
  );

  // a terminator is a lone zero byte with a defined status and a length
  `U8E_ASSERT_IMPL(a_term_shape, out_valid && out_is_terminator,
    (out_byte == 8'h00) && out_end_of_item && (out_status != 2'd3) &&
    (out_string_length != 16'd0))
  // data bytes carry no status and no length
  `U8E_ASSERT_IMPL(a_data_clean, out_valid && !out_is_terminator,
    (out_status == u8enc_pkg::ST_OK) && (out_string_length == 16'd0))
  // continuation bytes follow on the very next cycle
  `U8E_ASSERT_NEXT(a_cont_follows, out_valid && out_ready && !out_end_of_item,
    out_valid && !out_is_terminator)

endmodule

FILE: test/utf32_to_utf8_string_encoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf32 to utf8 string encoder core testbench
// drives code words through the encoder, predicts every utf8 byte and
// terminator in a local model and checks each output item field by field
// ----------------------------------------------------------------------------
module utf32_to_utf8_string_encoder_core_tb;

  // one expected output item
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        term;
    logic [1:0]  status;
    logic [15:0] len;
  } utf8_byte_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [31:0]                      in_code_word = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [7:0]                       out_byte;
  logic                             out_end_of_item;
  logic                             out_is_terminator;
  logic [1:0]                       out_status;
  logic [15:0]                      out_string_length;
  logic                             cfg_we = 1'b0;
  logic [u8enc_pkg::CFG_IDX_W-1:0]  cfg_index = u8enc_pkg::REG_LITTLE_ENDIAN;
  logic [u8enc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // local copy of the encoder's configuration and string state
  bit          enc_le = 1'b0;
  logic [15:0] enc_cap = u8enc_pkg::CAP_RESET;
  bit          enc_err = 1'b0;
  int unsigned enc_used = 0;
  bit          enc_closed = 1'b0;

  // bytes and terminators still owed by the encoder, oldest first
  utf8_byte_t  bytes_due[$];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;

  // sender pacing: burst length left and the largest gap (0 = no gaps)
  int unsigned burst_left = 0;
  int unsigned gap_max = 0;
  bit          in_held = 1'b0;

  // receiver stall pattern, rotated one bit per cycle
  logic [15:0] stall_pat = 16'hFFFF;
  int unsigned stall_age = 0;

  always #2 clk = ~clk;

  utf32_to_utf8_string_encoder_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_code_word      (in_code_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_end_of_item   (out_end_of_item),
    .out_is_terminator (out_is_terminator),
    .out_status        (out_status),
    .out_string_length (out_string_length),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  function automatic logic [31:0] byte_swap(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // code point as it has to appear on the wire under the current byte order
  function automatic logic [31:0] to_wire(input logic [31:0] cp);
    return enc_le ? byte_swap(cp) : cp;
  endfunction

  function automatic void push_data(input logic [7:0] b, input logic last);
    bytes_due.push_back(utf8_byte_t'{b, last, 1'b0, u8enc_pkg::ST_OK, 16'd0});
  endfunction

  // terminator carries the length so far plus itself, then the count restarts
  function automatic void push_term(input logic [1:0] status, input bit close);
    bytes_due.push_back(utf8_byte_t'{8'h00, 1'b1, 1'b1, status, 16'(enc_used + 1)});
    enc_used   = 0;
    enc_closed = close;
  endfunction

  function automatic void encode_word(input logic [31:0] raw);
    logic [31:0] cp;
    int unsigned n;
    int unsigned lim;
    cp = enc_le ? byte_swap(raw) : raw;
    // zero word: end of string, or silent reopen after an early close
    if (cp == 32'd0) begin
      if (enc_closed) begin
        enc_closed = 1'b0;
        enc_used   = 0;
      end else begin
        push_term(enc_err ? u8enc_pkg::ST_INVALID : u8enc_pkg::ST_OK, 1'b0);
      end
      return;
    end
    // words of a closed string are dropped
    if (enc_closed) return;
    // sticky error: every open string ends at its first word
    if (enc_err) begin
      push_term(u8enc_pkg::ST_INVALID, 1'b1);
      return;
    end
    // beyond the unicode range or a surrogate
    if (cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF)) begin
      enc_err = 1'b1;
      push_term(u8enc_pkg::ST_INVALID, 1'b1);
      return;
    end
    if (cp < 32'h80) n = 1;
    else if (cp < 32'h800) n = 2;
    else if (cp < 32'h10000) n = 3;
    else n = 4;
    // a zero capacity behaves as one byte, just room for the terminator
    lim = (enc_cap == 16'd0) ? 1 : enc_cap;
    if (enc_used + n >= lim) begin
      push_term(u8enc_pkg::ST_TRUNC, 1'b1);
      return;
    end
    case (n)
      1: push_data(cp[7:0], 1'b1);
      2: begin
        push_data({3'b110, cp[10:6]}, 1'b0);
        push_data({2'b10, cp[5:0]}, 1'b1);
      end
      3: begin
        push_data({4'b1110, cp[15:12]}, 1'b0);
        push_data({2'b10, cp[11:6]}, 1'b0);
        push_data({2'b10, cp[5:0]}, 1'b1);
      end
      default: begin
        push_data({5'b11110, cp[20:18]}, 1'b0);
        push_data({2'b10, cp[17:12]}, 1'b0);
        push_data({2'b10, cp[11:6]}, 1'b0);
        push_data({2'b10, cp[5:0]}, 1'b1);
      end
    endcase
    enc_used += n;
  endfunction

  // scalar value of any utf8 length, surrogates excluded
  function automatic logic [31:0] valid_code_point();
    logic [31:0] cp;
    case ($urandom_range(0, 9))
      0, 1, 2: cp = $urandom_range(32'h01, 32'h7F);
      3, 4:    cp = $urandom_range(32'h80, 32'h7FF);
      5, 6: begin
        cp = $urandom_range(32'h800, 32'hF7FF);
        if (cp >= 32'hD800) cp += 32'h800;
      end
      7, 8:    cp = $urandom_range(32'h10000, 32'h10FFFF);
      default: begin
        // boundaries of each length class and around the surrogate gap
        case ($urandom_range(0, 9))
          0: cp = 32'h01;
          1: cp = 32'h7F;
          2: cp = 32'h80;
          3: cp = 32'h7FF;
          4: cp = 32'h800;
          5: cp = 32'hD7FF;
          6: cp = 32'hE000;
          7: cp = 32'hFFFF;
          8: cp = 32'h10000;
          default: cp = 32'h10FFFF;
        endcase
      end
    endcase
    return cp;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers, all entered and left just after a rising edge
  // --------------------------------------------------------------------------

  // one word on the input channel; valid stays up across a burst
  task automatic send_word(input logic [31:0] w);
    in_valid     <= 1'b1;
    in_code_word <= w;
    in_held = 1'b1;
    do @(posedge clk); while (!in_ready);
    encode_word(w);
    words_sent++;
    if (gap_max != 0 && burst_left == 0) begin
      in_valid <= 1'b0;
      in_held = 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end else if (burst_left != 0) begin
      burst_left--;
    end
  endtask

  // hold the sender until every owed item has come out
  task automatic wait_idle();
    if (in_held) begin
      in_valid <= 1'b0;
      in_held = 1'b0;
    end
    while (bytes_due.size() != 0) @(posedge clk);
    // dropped words leave nothing in the queue, so let the pipe drain
    repeat (12) @(posedge clk);
  endtask

  // both registers, one per cycle, only while the encoder is idle
  task automatic set_config(input bit le, input logic [15:0] cap);
    cfg_we    <= 1'b1;
    cfg_index <= u8enc_pkg::REG_LITTLE_ENDIAN;
    cfg_wdata <= {15'd0, le};
    @(posedge clk);
    cfg_index <= u8enc_pkg::REG_OUT_CAPACITY;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    enc_le  = le;
    enc_cap = cap;
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // every length class, the multi-byte ones at their limits, big-endian, full capacity
  task automatic test_encode_lengths();
    gap_max = 6;
    send_word(32'h41);
    send_word(32'h7F);
    send_word(32'h80);
    send_word(32'h7FF);
    send_word(32'h800);
    send_word(32'hFFFF);
    send_word(32'h10000);
    send_word(32'h10FFFF);
    send_word(32'd0);
  endtask

  // early close on capacity, dropped words, silent reopen, zero capacity
  task automatic test_capacity();
    wait_idle();
    set_config(1'b0, 16'd5);
    send_word(32'h61);
    send_word(32'h62);
    send_word(32'h80);      // fills four of five bytes
    send_word(32'h63);      // no room left for the terminator
    send_word(32'h10000);   // dropped
    send_word(32'd0);       // reopens, nothing out
    send_word(32'd0);       // empty string
    wait_idle();
    set_config(1'b0, 16'd0);
    send_word(32'h61);
    send_word(32'd0);
    send_word(32'd0);
  endtask

  task automatic test_little_endian();
    wait_idle();
    set_config(1'b1, u8enc_pkg::CAP_RESET);
    send_word(32'h41000000);
    send_word(32'h00000100);  // swaps to the first four-byte code point
    send_word(32'd0);
  endtask

  // phases of random strings under random configurations, no invalid words
  task automatic test_random_strings(input int unsigned count);
    int unsigned stop_at;
    int unsigned phase_end;
    logic [15:0] cap;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      wait_idle();
      case ($urandom_range(0, 6))
        0:       cap = u8enc_pkg::CAP_RESET;
        1:       cap = 16'($urandom_range(49, 65535));
        2, 3:    cap = 16'($urandom_range(2, 12));
        4, 5:    cap = 16'($urandom_range(13, 48));
        default: cap = 16'($urandom_range(0, 1));
      endcase
      set_config($urandom_range(0, 1), cap);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      phase_end = words_sent + $urandom_range(25, 50);
      while (words_sent < phase_end && words_sent < stop_at) begin
        case ($urandom_range(0, 19))
          18: send_word(32'd0);  // stray end of string
          19: begin
            // fragment with no end, runs into the next string
            repeat ($urandom_range(1, 4)) send_word(to_wire(valid_code_point()));
          end
          default: begin
            repeat ($urandom_range(0, 12)) send_word(to_wire(valid_code_point()));
            send_word(32'd0);
          end
        endcase
      end
    end
  endtask

  // first invalid word latches the error for the rest of the run
  task automatic test_invalid_code_point();
    wait_idle();
    set_config(1'b0, u8enc_pkg::CAP_RESET);
    gap_max = 6;
    send_word(32'h61);
    send_word(32'h0000D800);  // surrogate closes the string with an error
    send_word(32'h62);        // dropped
    send_word(32'd0);         // reopens, nothing out
    send_word(32'h63);        // sticky error closes at the first word
    send_word(32'd0);
    send_word(32'd0);         // empty string still flags the error
    send_word(32'h0000DFFF);
    send_word(32'h00110000);
    send_word(32'd0);
    send_word(32'hFFFFFFFF);
  endtask

  // raw random words once the error is latched; covers the upper word bits
  task automatic test_random_after_error(input int unsigned count);
    int unsigned stop_at;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      wait_idle();
      set_config($urandom_range(0, 1), 16'($urandom));
      gap_max = $urandom_range(0, 1) ? 6 : 0;
      repeat ($urandom_range(10, 20)) begin
        case ($urandom_range(0, 3))
          0:       send_word(32'd0);
          1:       send_word(to_wire(valid_code_point()));
          default: send_word($urandom);
        endcase
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // output side: stall pattern and checking of every accepted item
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    utf8_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (bytes_due.size() == 0) begin
        $error("item with nothing expected: out_byte %02h", out_byte);
        mismatches++;
      end else begin
        want = bytes_due.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_byte);
          mismatches++;
        end
        if (out_end_of_item !== want.last) begin
          $error("out_end_of_item: expected %0b, got %0b", want.last, out_end_of_item);
          mismatches++;
        end
        if (out_is_terminator !== want.term) begin
          $error("out_is_terminator: expected %0b, got %0b", want.term, out_is_terminator);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_string_length !== want.len) begin
          $error("out_string_length: expected %0d, got %0d", want.len, out_string_length);
          mismatches++;
        end
      end
    end
    // new stall pattern whenever the age runs out: none, dense, sparse or regular
    if (stall_age == 0) begin
      stall_age = 40;
      case ($urandom_range(0, 3))
        0:       stall_pat = 16'hFFFF;
        1:       stall_pat = 16'($urandom) | 16'h0001;
        2:       stall_pat = 16'($urandom & $urandom) | 16'h0001;
        default: stall_pat = 16'h0101;
      endcase
    end
    stall_age--;
    out_ready <= stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[15:1]};
  end

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_encode_lengths();
    test_capacity();
    test_little_endian();
    test_random_strings(270);
    test_invalid_code_point();
    test_random_after_error(60);
    wait_idle();
    if (mismatches == 0 && bytes_due.size() == 0)
      $display("utf32_to_utf8_string_encoder_core_tb passed");
    else
      $display("utf32_to_utf8_string_encoder_core_tb failed");
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #2_000_000;
    $display("utf32_to_utf8_string_encoder_core_tb failed");
    $finish;
  end

endmodule
